// ===== src/gmdfs_pkg.sv =====
package gmdfs_pkg;

  // operation codes of the input opcode field
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_WALL   = 3'd1,
    OP_SEARCH = 3'd2,
    OP_QUERY  = 3'd3,
    OP_POP    = 3'd4
  } op_e;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // passage bits of one cell
  localparam logic [3:0] PASS_LEFT  = 4'd1;
  localparam logic [3:0] PASS_DOWN  = 4'd2;
  localparam logic [3:0] PASS_RIGHT = 4'd4;
  localparam logic [3:0] PASS_UP    = 4'd8;
  localparam logic [3:0] PASS_ALL   = 4'd15;

  localparam int unsigned CFG_W  = 7;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned IN_W   = 24;
  localparam int unsigned OUT_W  = 32;

  // sequencer states
  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_CLR    = 14'b00000000000010,
    ST_WRD    = 14'b00000000000100,
    ST_WWR    = 14'b00000000001000,
    ST_SCLR   = 14'b00000000010000,
    ST_WTOP   = 14'b00000000100000,
    ST_WPASS  = 14'b00000001000000,
    ST_WNBR   = 14'b00000010000000,
    ST_WCHK   = 14'b00000100000000,
    ST_QRD    = 14'b00001000000000,
    ST_QCHK   = 14'b00010000000000,
    ST_PRD    = 14'b00100000000000,
    ST_PDAT   = 14'b01000000000000,
    ST_OUT    = 14'b10000000000000
  } state_e;

  typedef struct packed {
    logic       status;
    logic       reached;
    logic [12:0] path_length;
    logic [6:0] cell_row;
    logic [6:0] cell_col;
    logic       path_last;
  } result_t;

endpackage

// ===== src/gmdfs_mem.sv =====
module gmdfs_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/grid_maze_dfs_path.sv =====
// channel  | dir | beat fields (lsb first)
// s_axis   | in  | opcode[2:0] wall_vertical cell_row_in[6:0] cell_col_in[6:0]
// m_axis   | out | status reached path_length[12:0] cell_row_out cell_col_out path_last
// cfg      | in  | index 0 grid_rows, 1 grid_cols
//
// clear sweeps passages over all N = 2**($clog2(MAX_ROWS)+$clog2(MAX_COLS)) cells (4096 at
// defaults); search first sweeps the visited marks over N cells, then walks the maze; empty
// pop, unused opcodes and queries off the grid go straight to the output state
// reset clears control state only; passages and visited marks are swept before tready rises;
// a finished item waits in its last state while the result is held
module grid_maze_dfs_path
  import gmdfs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // opcode[2:0], wall_vertical[3], cell_row_in[10:4], cell_col_in[17:11]
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[0], reached[1], path_length[14:2], cell_row_out[21:15], cell_col_out[28:22]
  output logic [OUT_W-1:0]     m_axis_tdata,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned CELLS = 2 ** AW;
  localparam int unsigned SW    = AW + 1;
  localparam int unsigned DW    = 12;

  state_e state_q, state_d;
  logic [DW-1:0] rows_q, cols_q, rows_d, cols_d;
  logic [DW-1:0] used_rows, used_cols;
  logic [AW:0]   sweep_q, sweep_d;
  logic          init_q, init_d;
  logic          vert_q, vert_d;
  logic [DW-1:0] r_q, c_q, r_d, c_d;
  logic          side_q, side_d;
  logic [SW-1:0] sp_q, sp_d;
  logic [SW-1:0] pcnt_q, pcnt_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [2:0]    dir_q, dir_d;
  logic [AW-1:0] nbr_q, nbr_d;
  result_t       res_q, res_d;
  result_t       out_q, out_d;
  logic          ovalid_q, ovalid_d;

  // memory ports
  logic          pb_we, vm_we, pa_we, ws_we, ps_we;
  logic [AW-1:0] pb_wa, vm_wa, pa_wa, ws_wa, ps_wa;
  logic [AW-1:0] pb_ra, vm_ra, pa_ra, ws_ra, ps_ra;
  logic [3:0]    pb_wd, pb_rd;
  logic [0:0]    vm_wd, vm_rd;
  logic [AW:0]   pa_wd, pa_rd;
  logic [AW+2:0] ws_wd, ws_rd;
  logic [AW-1:0] ps_wd, ps_rd;

  gmdfs_mem #(.DEPTH(CELLS), .WIDTH(4)) u_pass (
    .clk_i, .we_i(pb_we), .waddr_i(pb_wa), .wdata_i(pb_wd), .raddr_i(pb_ra), .rdata_o(pb_rd));
  gmdfs_mem #(.DEPTH(CELLS), .WIDTH(1)) u_visit (
    .clk_i, .we_i(vm_we), .waddr_i(vm_wa), .wdata_i(vm_wd), .raddr_i(vm_ra), .rdata_o(vm_rd));
  gmdfs_mem #(.DEPTH(CELLS), .WIDTH(AW+1)) u_parent (
    .clk_i, .we_i(pa_we), .waddr_i(pa_wa), .wdata_i(pa_wd), .raddr_i(pa_ra), .rdata_o(pa_rd));
  gmdfs_mem #(.DEPTH(CELLS), .WIDTH(AW+3)) u_walk (
    .clk_i, .we_i(ws_we), .waddr_i(ws_wa), .wdata_i(ws_wd), .raddr_i(ws_ra), .rdata_o(ws_rd));
  gmdfs_mem #(.DEPTH(CELLS), .WIDTH(AW)) u_path (
    .clk_i, .we_i(ps_we), .waddr_i(ps_wa), .wdata_i(ps_wd), .raddr_i(ps_ra), .rdata_o(ps_rd));

  // grid limits clamp to the maximum
  assign used_rows = (rows_q > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : rows_q;
  assign used_cols = (cols_q > DW'(MAX_COLS)) ? DW'(MAX_COLS) : cols_q;

  function automatic logic in_grid(input logic [DW-1:0] r, input logic [DW-1:0] c,
                                   input logic [DW-1:0] ur, input logic [DW-1:0] uc);
    return (r >= DW'(1)) && (c >= DW'(1)) && (r <= ur) && (c <= uc);
  endfunction

  function automatic logic [AW-1:0] cell_idx(input logic [DW-1:0] r, input logic [DW-1:0] c);
    logic [RW-1:0] rr;
    logic [CW-1:0] cc;
    rr = RW'(r - DW'(1));
    cc = CW'(c - DW'(1));
    return {rr, cc};
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE) && init_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, out_q.cell_col, out_q.cell_row, out_q.path_length,
                          out_q.reached, out_q.status};
  assign m_axis_tlast  = out_q.path_last;

  logic [DW-1:0] cur_r, cur_c, nr, nc;
  logic [DW-1:0] in_r, in_c;
  assign cur_r = DW'(cur_q[AW-1:CW]) + DW'(1);
  assign cur_c = DW'(cur_q[CW-1:0]) + DW'(1);
  assign in_r  = DW'(s_axis_tdata[10:4]);
  assign in_c  = DW'(s_axis_tdata[17:11]);

  // neighbor of the current cell in direction dir
  always_comb begin
    nr = cur_r;
    nc = cur_c;
    case (dir_q[1:0])
      2'd0:    nc = cur_c - DW'(1);
      2'd1:    nr = cur_r + DW'(1);
      2'd2:    nc = cur_c + DW'(1);
      default: nr = cur_r - DW'(1);
    endcase
  end

  always_comb begin
    state_d = state_q; rows_d = rows_q; cols_d = cols_q; sweep_d = sweep_q;
    init_d = init_q; vert_d = vert_q; r_d = r_q; c_d = c_q;
    side_d = side_q; sp_d = sp_q; pcnt_d = pcnt_q; cur_d = cur_q; dir_d = dir_q;
    nbr_d = nbr_q; res_d = res_q; out_d = out_q; ovalid_d = ovalid_q;
    pb_we = 1'b0; pb_wa = sweep_q[AW-1:0]; pb_wd = PASS_ALL; pb_ra = cur_q;
    vm_we = 1'b0; vm_wa = sweep_q[AW-1:0]; vm_wd = 1'b0;     vm_ra = nbr_q;
    pa_we = 1'b0; pa_wa = nbr_q;           pa_wd = '0;       pa_ra = cur_q;
    ws_we = 1'b0; ws_wa = '0;              ws_wd = '0;       ws_ra = AW'(sp_q - SW'(1));
    ps_we = 1'b0; ps_wa = AW'(pcnt_q);     ps_wd = cur_q;    ps_ra = AW'(pcnt_q - SW'(1));

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_ROWS) rows_d = DW'(cfg_data_i);
      else                         rows_d = rows_q;
      if (cfg_index_i == CFG_COLS) cols_d = DW'(cfg_data_i);
    end
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!init_q) begin
          // post-reset sweep of passages and visited marks
          pb_we = 1'b1; vm_we = 1'b1;
          sweep_d = sweep_q + 1'b1;
          if (sweep_q == (AW+1)'(CELLS - 1)) begin
            init_d = 1'b1; sweep_d = '0;
          end
        end else if (s_axis_tvalid) begin
          vert_d = s_axis_tdata[3];
          r_d = in_r; c_d = in_c;
          res_d = '0;
          sweep_d = '0;
          case (s_axis_tdata[2:0])
            OP_CLEAR:  state_d = ST_CLR;
            OP_WALL: begin
              side_d = 1'b0;
              cur_d = cell_idx(in_r, in_c);
              state_d = ST_WRD;
            end
            OP_SEARCH: state_d = ST_SCLR;
            OP_QUERY: begin
              pcnt_d = '0;
              cur_d = cell_idx(in_r, in_c);
              nbr_d = cell_idx(in_r, in_c);
              state_d = in_grid(in_r, in_c, used_rows, used_cols) ? ST_QRD : ST_OUT;
            end
            OP_POP: begin
              if (pcnt_q == '0) begin
                res_d.status = 1'b1; state_d = ST_OUT;
              end else begin
                state_d = ST_PRD;
              end
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_CLR: begin
        pb_we = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == (AW+1)'(CELLS - 1)) state_d = ST_OUT;
      end
      // wall: read the cell, then write it back with the bit cleared
      ST_WRD: begin
        if (in_grid(r_q, c_q, used_rows, used_cols)) begin
          pb_ra = cell_idx(r_q, c_q);
          cur_d = cell_idx(r_q, c_q);
          state_d = ST_WWR;
        end else begin
          state_d = ST_WWR;
          cur_d = cell_idx(r_q, c_q);
          side_d = side_q;
          sweep_d = {1'b1, {AW{1'b0}}};
        end
      end
      ST_WWR: begin
        if (!sweep_q[AW]) begin
          pb_we = 1'b1; pb_wa = cur_q;
          if (!side_q) pb_wd = pb_rd & ~(vert_q ? PASS_RIGHT : PASS_DOWN);
          else         pb_wd = pb_rd & ~(vert_q ? PASS_LEFT : PASS_UP);
        end
        sweep_d = '0;
        if (side_q) begin
          state_d = ST_OUT;
        end else begin
          side_d = 1'b1;
          if (vert_q) c_d = c_q + DW'(1);
          else        r_d = r_q + DW'(1);
          state_d = ST_WRD;
        end
      end
      // search: clear visited marks, then walk
      ST_SCLR: begin
        vm_we = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == (AW+1)'(CELLS - 1)) begin
          if (in_grid(r_q, c_q, used_rows, used_cols)) begin
            vm_we = 1'b1; // last clear goes to sweep address; start is set next
            state_d = ST_WTOP;
            cur_d = cell_idx(r_q, c_q);
            sp_d = SW'(1);
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_WTOP: begin
        // first entry: mark start, push it
        if (sp_q == SW'(1) && sweep_q[AW]) begin
          vm_we = 1'b1; vm_wa = cur_q; vm_wd = 1'b1;
          pa_we = 1'b1; pa_wa = cur_q; pa_wd = {1'b1, {AW{1'b0}}};
          ws_we = 1'b1; ws_wa = '0; ws_wd = {3'd0, cur_q};
          sweep_d = '0;
          state_d = ST_WTOP;
        end else if (sp_q == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_WPASS;
        end
      end
      ST_WPASS: begin
        // walk stack top is on ws_rd
        cur_d = ws_rd[AW-1:0];
        dir_d = ws_rd[AW+2:AW];
        pb_ra = ws_rd[AW-1:0];
        if (ws_rd[AW+2]) begin
          sp_d = sp_q - SW'(1);
          state_d = ST_WTOP;
        end else begin
          ws_we = 1'b1; ws_wa = AW'(sp_q - SW'(1));
          ws_wd = {ws_rd[AW+2:AW] + 3'd1, ws_rd[AW-1:0]};
          state_d = ST_WNBR;
        end
      end
      ST_WNBR: begin
        if (pb_rd[dir_q[1:0]] && in_grid(nr, nc, used_rows, used_cols)) begin
          nbr_d = cell_idx(nr, nc);
          vm_ra = cell_idx(nr, nc);
          state_d = ST_WCHK;
        end else begin
          state_d = ST_WTOP;
        end
      end
      ST_WCHK: begin
        if (!vm_rd[0] && sp_q < SW'(CELLS)) begin
          vm_we = 1'b1; vm_wa = nbr_q; vm_wd = 1'b1;
          pa_we = 1'b1; pa_wa = nbr_q; pa_wd = {1'b0, cur_q};
          ws_we = 1'b1; ws_wa = AW'(sp_q); ws_wd = {3'd0, nbr_q};
          sp_d = sp_q + SW'(1);
        end
        state_d = ST_WTOP;
      end
      // query: check visited, then follow parents
      ST_QRD: begin
        vm_ra = nbr_q;
        pa_ra = nbr_q;
        state_d = ST_QCHK;
      end
      ST_QCHK: begin
        if (pcnt_q == '0 && !vm_rd[0]) begin
          state_d = ST_OUT;
        end else begin
          ps_we = 1'b1; ps_wa = AW'(pcnt_q); ps_wd = nbr_q;
          pcnt_d = pcnt_q + SW'(1);
          if (pa_rd[AW] || pcnt_q + SW'(1) >= SW'(CELLS)) begin
            res_d.reached = 1'b1;
            res_d.path_length = LEN_W'(pcnt_q + SW'(1));
            state_d = ST_OUT;
          end else begin
            nbr_d = pa_rd[AW-1:0];
            state_d = ST_QRD;
          end
        end
      end
      ST_PRD: begin
        state_d = ST_PDAT;
      end
      ST_PDAT: begin
        pcnt_d = pcnt_q - SW'(1);
        res_d.cell_row = 7'(DW'(ps_rd[AW-1:CW]) + DW'(1));
        res_d.cell_col = 7'(DW'(ps_rd[CW-1:0]) + DW'(1));
        res_d.path_last = (pcnt_q == SW'(1));
        res_d.path_length = LEN_W'(pcnt_q - SW'(1));
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hand the result over once the output register is free
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          out_d = res_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // search start flag: sweep done marks first push
    if (state_q == ST_SCLR && state_d == ST_WTOP) sweep_d = {1'b1, {AW{1'b0}}};
    // walk top read address
    if (state_d == ST_WPASS) ws_ra = AW'(sp_d - SW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; rows_q <= DW'(64); cols_q <= DW'(64);
      sweep_q <= '0; init_q <= 1'b0; pcnt_q <= '0; sp_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; rows_q <= rows_d; cols_q <= cols_d;
      sweep_q <= sweep_d; init_q <= init_d; pcnt_q <= pcnt_d; sp_q <= sp_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vert_q <= vert_d; r_q <= r_d; c_q <= c_d; side_q <= side_d;
    cur_q <= cur_d; dir_q <= dir_d; nbr_q <= nbr_d; res_q <= res_d; out_q <= out_d;
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import gmdfs_pkg::*;

  localparam int ROWS_MAX = 64;
  localparam int COLS_MAX = 64;
  localparam int NCELL = ROWS_MAX * COLS_MAX;
  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int ROOT = -1;
  localparam logic [2:0] OP_SPARE = 3'd5;

  typedef struct packed {
    logic        status;
    logic        reached;
    logic [12:0] path_length;
    logic [6:0]  cell_row;
    logic [6:0]  cell_col;
    logic        path_last;
  } maze_res_t;

  typedef struct {
    logic [2:0] op;
    logic       vert;
    logic [6:0] row;
    logic [6:0] col;
    bit         typed;
    maze_res_t  res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  grid_maze_dfs_path dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // maze mirror
  logic [3:0] passage_m[NCELL];
  bit         seen_m[NCELL];
  int         parent_m[NCELL];
  int         dfs_cell[NCELL];
  int         dfs_dir[NCELL];
  int         route_m[NCELL];
  int         route_cnt;
  int         rows_reg;
  int         cols_reg;

  maze_res_t  pending_results[$];
  int         errors = 0;
  int         cycles = 0;
  int         beats = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int rows_used();
    return (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
  endfunction

  function automatic int cols_used();
    return (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
  endfunction

  function automatic bit on_grid(int r, int c);
    return r >= 1 && c >= 1 && r <= rows_used() && c <= cols_used();
  endfunction

  function automatic void close_side(int r, int c, logic [3:0] bits);
    if (on_grid(r, c))
      passage_m[(r-1)*COLS_MAX + c-1] &= ~bits;
  endfunction

  // depth-first walk, neighbors tried left, down, right, up
  function automatic void dfs_walk(int r0, int c0);
    int sp, top, d, r, c, nr, nc, n;
    foreach (seen_m[i]) seen_m[i] = 0;
    if (!on_grid(r0, c0)) return;
    top = (r0-1)*COLS_MAX + c0-1;
    seen_m[top] = 1;
    parent_m[top] = ROOT;
    dfs_cell[0] = top;
    dfs_dir[0] = 0;
    sp = 1;
    while (sp > 0) begin
      top = dfs_cell[sp-1];
      d = dfs_dir[sp-1];
      if (d >= 4) begin
        sp--;
        continue;
      end
      dfs_dir[sp-1] = d + 1;
      if (!passage_m[top][d]) continue;
      r = top / COLS_MAX + 1;
      c = top % COLS_MAX + 1;
      nr = r + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
      nc = c + ((d == 0) ? -1 : (d == 2) ? 1 : 0);
      if (!on_grid(nr, nc)) continue;
      n = (nr-1)*COLS_MAX + nc-1;
      if (seen_m[n]) continue;
      seen_m[n] = 1;
      parent_m[n] = top;
      dfs_cell[sp] = n;
      dfs_dir[sp] = 0;
      sp++;
    end
  endfunction

  function automatic maze_res_t maze_predict(logic [2:0] op, logic vert, int r, int c);
    maze_res_t res;
    int t;
    res = '0;
    case (op)
      OP_CLEAR: foreach (passage_m[i]) passage_m[i] = PASS_ALL;
      OP_WALL: begin
        if (vert) begin
          close_side(r, c, PASS_RIGHT);
          close_side(r, c + 1, PASS_LEFT);
        end else begin
          close_side(r, c, PASS_DOWN);
          close_side(r + 1, c, PASS_UP);
        end
      end
      OP_SEARCH: dfs_walk(r, c);
      OP_QUERY: begin
        route_cnt = 0;
        if (on_grid(r, c) && seen_m[(r-1)*COLS_MAX + c-1]) begin
          t = (r-1)*COLS_MAX + c-1;
          forever begin
            route_m[route_cnt++] = t;
            if (parent_m[t] == ROOT) break;
            t = parent_m[t];
          end
          res.reached = 1'b1;
          res.path_length = 13'(route_cnt);
        end
      end
      OP_POP: begin
        if (route_cnt == 0) begin
          res.status = 1'b1;
        end else begin
          t = route_m[--route_cnt];
          res.cell_row = 7'(t / COLS_MAX + 1);
          res.cell_col = 7'(t % COLS_MAX + 1);
          res.path_last = (route_cnt == 0);
          res.path_length = 13'(route_cnt);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic maze_res_t mk(bit st, bit rc, int len, int r, int c, bit lst);
    maze_res_t res;
    res.status = st;
    res.reached = rc;
    res.path_length = 13'(len);
    res.cell_row = 7'(r);
    res.cell_col = 7'(c);
    res.path_last = lst;
    return res;
  endfunction

  // input side: random gaps, valid kept high for back-to-back beats
  task automatic send_item(logic [2:0] op, logic vert, int r, int c,
                           bit typed = 0, maze_res_t res = '0);
    int gap;
    maze_res_t pred;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = '0;
    s_axis_tdata[2:0] = op;
    s_axis_tdata[3] = vert;
    s_axis_tdata[10:4] = r[6:0];
    s_axis_tdata[17:11] = c[6:0];
    do @(posedge clk_i); while (!s_axis_tready);
    pred = maze_predict(op, vert, r[6:0], c[6:0]);
    pending_results = {pending_results, (typed ? res : pred)};
    beats++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_grid(int r, int c);
    drain_results();
    cfg_we_i = 1'b1;
    cfg_index_i = CFG_ROWS;
    cfg_data_i = r[6:0];
    @(negedge clk_i);
    cfg_index_i = CFG_COLS;
    cfg_data_i = c[6:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    rows_reg = r;
    cols_reg = c;
  endtask

  // mostly just around the grid, sometimes anywhere in the field range
  function automatic int pick_coord(int lim);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
    return $urandom_range(1, lim + 1);
  endfunction

  // well-formed sequence: optional clear, walls, one search, then queries each followed by pops
  task automatic maze_episode();
    int nwall, npop, nq;
    if ($urandom_range(0, 1)) send_item(OP_CLEAR, 0, 0, 0);
    nwall = $urandom_range(2, 30);
    repeat (nwall)
      send_item(OP_WALL, 1'($urandom_range(0, 1)), pick_coord(rows_used()),
                pick_coord(cols_used()));
    send_item(OP_SEARCH, 0, pick_coord(rows_used()), pick_coord(cols_used()));
    nq = $urandom_range(1, 3);
    repeat (nq) begin
      send_item(OP_QUERY, 0, pick_coord(rows_used()), pick_coord(cols_used()));
      npop = route_cnt + $urandom_range(0, 1);
      if (npop > 40) npop = $urandom_range(1, 40);
      repeat (npop) send_item(OP_POP, 0, pick_coord(127), pick_coord(127));
    end
    // occasional noise: spare opcodes, walls, queries and pops with any fields
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_item($urandom_range(0, 1) ? 3'(OP_SPARE + $urandom_range(0, 2)) :
                  ($urandom_range(0, 2) == 0) ? OP_WALL :
                  ($urandom_range(0, 1) ? OP_QUERY : OP_POP),
                  1'($urandom_range(0, 1)), $urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  // output side: random stalls with stretches of steady ready
  initial begin
    int hold;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin m_axis_tready = 1'b1; hold = $urandom_range(0, 30); end
          4, 5, 6, 7: begin m_axis_tready = $urandom_range(0, 1); hold = 0; end
          8: begin m_axis_tready = 1'b0; hold = $urandom_range(1, 4); end
          default: begin m_axis_tready = 1'b0; hold = $urandom_range(15, 50); end
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    maze_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[0];
      got.reached = m_axis_tdata[1];
      got.path_length = m_axis_tdata[14:2];
      got.cell_row = m_axis_tdata[21:15];
      got.cell_col = m_axis_tdata[28:22];
      got.path_last = m_axis_tlast;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.reached !== want.reached) begin
          $error("reached exp %0d got %0d", want.reached, got.reached); errors++;
        end
        if (got.path_length !== want.path_length) begin
          $error("path_length exp %0d got %0d", want.path_length, got.path_length);
          errors++;
        end
        if (got.cell_row !== want.cell_row) begin
          $error("cell_row_out exp %0d got %0d", want.cell_row, got.cell_row); errors++;
        end
        if (got.cell_col !== want.cell_col) begin
          $error("cell_col_out exp %0d got %0d", want.cell_col, got.cell_col); errors++;
        end
        if (got.path_last !== want.path_last) begin
          $error("path_last exp %0d got %0d", want.path_last, got.path_last); errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t dir_rows[$];
    maze_res_t zero;
    int phase_rows[$], phase_cols[$], phase_items[$];
    int budget, k;
    zero = '0;
    foreach (passage_m[i]) passage_m[i] = PASS_ALL;
    route_cnt = 0;
    rows_reg = 64;
    cols_reg = 64;

    // directed rows on the reset grid
    dir_rows = '{
      '{OP_POP,    0,   0,   0, 1, mk(1, 0, 0, 0, 0, 0)},
      '{OP_QUERY,  0,   1,   1, 1, zero},
      '{OP_SPARE,  1, 127, 127, 1, zero},
      '{3'd7,      1, 127, 127, 1, zero},
      '{OP_WALL,   1,  64,  64, 1, zero},
      '{OP_WALL,   0,  64,  64, 1, zero},
      '{OP_WALL,   0,   0,   0, 1, zero},
      '{OP_WALL,   1,   1,   1, 1, zero},
      '{OP_WALL,   1,   1,   1, 1, zero},
      '{OP_WALL,   0,   1,   1, 1, zero},
      '{OP_SEARCH, 0,   0,   0, 1, zero},
      '{OP_QUERY,  0,   1,   1, 1, zero},
      '{OP_SEARCH, 0,   1,   2, 1, zero},
      '{OP_QUERY,  0,   1,   2, 1, mk(0, 1, 1, 0, 0, 0)},
      '{OP_POP,    0,   0,   0, 1, mk(0, 0, 0, 1, 2, 1)},
      '{OP_QUERY,  0, 127, 127, 1, zero},
      '{OP_POP,    0,   0,   0, 1, mk(1, 0, 0, 0, 0, 0)},
      '{OP_QUERY,  0,   1,   1, 0, zero},
      '{OP_POP,    0,   0,   0, 0, zero},
      '{OP_POP,    0,   0,   0, 0, zero},
      '{OP_QUERY,  0,  64,  64, 0, zero},
      '{OP_POP,    0,   5,   9, 0, zero},
      '{OP_CLEAR,  0,   0,   0, 1, zero},
      '{OP_QUERY,  0,   1,   1, 0, zero},
      '{OP_POP,    0,   0,   0, 0, zero}
    };

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].vert, dir_rows[i].row, dir_rows[i].col,
                dir_rows[i].typed, dir_rows[i].res);

    // grid settings: extremes first, then small random grids
    phase_rows = '{1, 0, 127, 64, 2, 5};
    phase_cols = '{1, 5, 127, 2, 64, 0};
    phase_items = '{60, 40, 70, 90, 90, 30};
    for (k = 0; k < 12; k++) begin
      phase_rows = {phase_rows, int'($urandom_range(1, 10))};
      phase_cols = {phase_cols, int'($urandom_range(1, 10))};
      phase_items = {phase_items, 120};
    end
    foreach (phase_rows[p]) begin
      set_grid(phase_rows[p], phase_cols[p]);
      budget = beats + phase_items[p];
      while (beats < budget) maze_episode();
    end

    drain_results();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== grid_maze_dfs_path.f =====
src/gmdfs_pkg.sv
src/gmdfs_mem.sv
src/grid_maze_dfs_path.sv
tb/tb.sv
